// ===== design/mcs_pkg.sv =====
// Shared types and constants for the motion capture segmenter.
package mcs_pkg;

    localparam int ACC_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 8;
    localparam int PERIOD_W   = 16;
    localparam int THR_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SQ_W       = 31;   // one squared axis, at most 2^30
    localparam int SUMSQ_W    = 32;   // three squared axes, below 2^32
    localparam int REASON_W   = 2;

    // Command codes of an input beat
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd4;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd20;
    localparam logic [CNT_W-1:0]    RST_MIN    = 8'd50;
    localparam logic [CNT_W-1:0]    RST_MAX    = 8'd125;
    localparam logic [THR_W-1:0]    RST_UPPER  = 16'd1040;
    localparam logic [THR_W-1:0]    RST_LOWER  = 16'd1010;

    typedef enum logic [REASON_W-1:0] {
        END_NONE  = 2'd0,
        END_STILL = 2'd1,
        END_MAX   = 2'd2
    } mcs_reason_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQRT,
        BK_UPD,
        BK_DEC
    } mcs_bk_state_t;

    typedef struct packed {
        logic                    cmd;
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
        logic [TIME_W-1:0]       time_ms;
    } mcs_item_t;

    typedef struct packed {
        mcs_item_t          item;
        logic [SUMSQ_W-1:0] sumsq;
    } mcs_work_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] sample_period_ms;
        logic [CNT_W-1:0]    min_samples;
        logic [CNT_W-1:0]    max_samples;
        logic [THR_W-1:0]    still_upper;
        logic [THR_W-1:0]    still_lower;
    } mcs_cfg_t;

    typedef struct packed {
        logic                    recorded;
        logic [CNT_W-1:0]        sample_index;
        logic [TIME_W-1:0]       rel_time_ms;
        logic signed [ACC_W-1:0] out_x;
        logic signed [ACC_W-1:0] out_y;
        logic signed [ACC_W-1:0] out_z;
        logic                    last;
        mcs_reason_t             end_reason;
        logic                    started;
    } mcs_result_t;

endpackage

// ===== design/mcs_front.sv =====
// Front end: accept beats and compute the squared vector length in two stages.
module mcs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mcs_pkg::mcs_item_t  in_item,
    output logic                push,
    output mcs_pkg::mcs_work_t  push_data,
    input  logic                fifo_full
);

    logic                         a_valid_reg;
    logic                         a_valid_next;
    mcs_pkg::mcs_item_t           a_item_reg;
    logic [mcs_pkg::SQ_W-1:0]     a_sqx_reg;
    logic [mcs_pkg::SQ_W-1:0]     a_sqy_reg;
    logic [mcs_pkg::SQ_W-1:0]     a_sqz_reg;
    logic                         b_valid_reg;
    logic                         b_valid_next;
    mcs_pkg::mcs_work_t           b_work_reg;
    logic                         b_adv;
    logic signed [2*mcs_pkg::ACC_W-1:0] px;
    logic signed [2*mcs_pkg::ACC_W-1:0] py;
    logic signed [2*mcs_pkg::ACC_W-1:0] pz;

    assign b_adv    = !b_valid_reg || !fifo_full;
    assign in_stall = a_valid_reg && !b_adv;
    assign push      = b_valid_reg && !fifo_full;
    assign push_data = b_work_reg;

    assign px = $signed(in_item.x) * $signed(in_item.x);
    assign py = $signed(in_item.y) * $signed(in_item.y);
    assign pz = $signed(in_item.z) * $signed(in_item.z);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (!in_stall)
        begin
            a_valid_next = in_valid;
        end
        if (b_adv)
        begin
            b_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            a_item_reg <= in_item;
            a_sqx_reg  <= px[mcs_pkg::SQ_W-1:0];
            a_sqy_reg  <= py[mcs_pkg::SQ_W-1:0];
            a_sqz_reg  <= pz[mcs_pkg::SQ_W-1:0];
        end
        if (a_valid_reg && b_adv)
        begin
            b_work_reg.item  <= a_item_reg;
            b_work_reg.sumsq <= mcs_pkg::SUMSQ_W'(a_sqx_reg)
                              + mcs_pkg::SUMSQ_W'(a_sqy_reg)
                              + mcs_pkg::SUMSQ_W'(a_sqz_reg);
        end
    end

endmodule

// ===== design/mcs_fifo.sv =====
// Two-entry queue between the front end and the back end.
module mcs_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mcs_pkg::mcs_work_t push_data,
    input  logic               pop,
    output mcs_pkg::mcs_work_t pop_data,
    output logic               full,
    output logic               empty
);

    mcs_pkg::mcs_work_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;
    logic [1:0]         fill_next;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !(pop && !empty))
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && pop && !empty)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/mcs_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module mcs_sqrt
#(
    parameter int IN_W = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [IN_W-1:0]     radicand,
    output logic                done,
    output logic [IN_W/2-1:0]   root
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;
    localparam int CNT_W = $clog2(OUT_W + 1);

    logic [IN_W-1:0]  rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [OUT_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_t = {rem_reg[REM_W-3:0], rad_reg[IN_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign fits  = (rem_t >= trial);
    assign done  = done_reg;
    assign root  = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(OUT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_t - trial) : rem_t;
            root_reg <= {root_reg[OUT_W-2:0], fits};
        end
    end

endmodule

// ===== design/mcs_back.sv =====
// Back end: recording control, magnitude window and result register.
module mcs_back
#(
    parameter int WINDOW_LEN    = 30,
    parameter int MAG_FRAC_BITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcs_pkg::mcs_cfg_t    cfg,
    input  logic                 empty,
    input  mcs_pkg::mcs_work_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mcs_pkg::mcs_result_t result
);

    localparam int MAG_W = mcs_pkg::ACC_W + MAG_FRAC_BITS;
    localparam int RAD_W = mcs_pkg::SUMSQ_W + 2 * MAG_FRAC_BITS;
    localparam int PTR_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = MAG_W + $clog2(WINDOW_LEN);
    localparam int HI_W  = mcs_pkg::THR_W + MAG_FRAC_BITS + 7;

    mcs_pkg::mcs_bk_state_t state_reg;
    mcs_pkg::mcs_bk_state_t state_next;

    logic                           recording_reg;
    logic [mcs_pkg::CNT_W-1:0]      count_reg;
    logic [mcs_pkg::TIME_W-1:0]     start_time_reg;
    logic [mcs_pkg::TIME_W-1:0]     last_time_reg;
    logic [PTR_W-1:0]               ptr_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic                           out_valid_reg;
    mcs_pkg::mcs_result_t           res_reg;
    mcs_pkg::mcs_item_t             cur_reg;
    logic [MAG_W-1:0]               ring_mem [WINDOW_LEN];
    logic [MAG_W-1:0]               old_mag_reg;
    logic [HI_W-1:0]                hi_reg;
    logic [HI_W-1:0]                lo_reg;

    logic                           out_free;
    logic                           is_start;
    logic                           take;
    logic [mcs_pkg::TIME_W-1:0]     elapsed;
    logic                           sqrt_start;
    logic                           sqrt_done;
    logic [MAG_W-1:0]               mag;
    logic                           load_idle;
    logic                           load_dec;
    logic                           do_upd;
    logic [mcs_pkg::CNT_W-1:0]      eff_min;
    logic                           still;
    logic                           maxed;
    mcs_pkg::mcs_reason_t           reason;
    logic [SUM_W-1:0]               sub_val;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    assign is_start = (head.item.cmd == mcs_pkg::CMD_START);
    assign elapsed  = head.item.time_ms - last_time_reg;
    assign take     = (head.item.cmd == mcs_pkg::CMD_SAMPLE) && recording_reg
                      && (elapsed >= mcs_pkg::TIME_W'(cfg.sample_period_ms));

    assign eff_min = (cfg.min_samples < mcs_pkg::CNT_W'(WINDOW_LEN))
                     ? mcs_pkg::CNT_W'(WINDOW_LEN) : cfg.min_samples;
    assign still   = (count_reg >= eff_min)
                     && (HI_W'(sum_reg) < hi_reg) && (HI_W'(sum_reg) > lo_reg);
    assign maxed   = (count_reg >= cfg.max_samples);
    assign sub_val = (count_reg >= mcs_pkg::CNT_W'(WINDOW_LEN)) ? SUM_W'(old_mag_reg) : '0;

    always_comb
    begin
        priority if (still)
        begin
            reason = mcs_pkg::END_STILL;
        end
        else if (maxed)
        begin
            reason = mcs_pkg::END_MAX;
        end
        else
        begin
            reason = mcs_pkg::END_NONE;
        end
    end

    mcs_sqrt #(
        .IN_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (RAD_W'(head.sumsq) << (2 * MAG_FRAC_BITS)),
        .done     (sqrt_done),
        .root     (mag)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcs_pkg::BK_IDLE:
            begin
                if (!empty && out_free && take)
                begin
                    state_next = mcs_pkg::BK_SQRT;
                end
            end
            mcs_pkg::BK_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = mcs_pkg::BK_UPD;
                end
            end
            mcs_pkg::BK_UPD:
            begin
                state_next = mcs_pkg::BK_DEC;
            end
            mcs_pkg::BK_DEC:
            begin
                if (out_free)
                begin
                    state_next = mcs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mcs_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        pop        = 1'b0;
        sqrt_start = 1'b0;
        load_idle  = 1'b0;
        load_dec   = 1'b0;
        do_upd     = 1'b0;
        unique case (state_reg)
            mcs_pkg::BK_IDLE:
            begin
                pop        = !empty && out_free;
                sqrt_start = pop && take;
                load_idle  = pop && !take;
            end
            mcs_pkg::BK_SQRT:
            begin
            end
            mcs_pkg::BK_UPD:
            begin
                do_upd = 1'b1;
            end
            mcs_pkg::BK_DEC:
            begin
                load_dec = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mcs_pkg::BK_IDLE;
            recording_reg  <= 1'b0;
            count_reg      <= '0;
            start_time_reg <= '0;
            last_time_reg  <= '0;
            ptr_reg        <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_idle || load_dec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // Arm a new recording
            if (load_idle && is_start && !recording_reg)
            begin
                recording_reg  <= 1'b1;
                count_reg      <= '0;
                start_time_reg <= head.item.time_ms;
                last_time_reg  <= head.item.time_ms;
                ptr_reg        <= '0;
                sum_reg        <= '0;
            end
            if (do_upd)
            begin
                sum_reg       <= sum_reg - sub_val + SUM_W'(mag);
                count_reg     <= count_reg + mcs_pkg::CNT_W'(1);
                last_time_reg <= cur_reg.time_ms;
                ptr_reg       <= (ptr_reg == PTR_W'(WINDOW_LEN - 1))
                                 ? '0 : ptr_reg + PTR_W'(1);
            end
            if (load_dec && (reason != mcs_pkg::END_NONE))
            begin
                recording_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        old_mag_reg <= ring_mem[ptr_reg];
        hi_reg <= HI_W'((HI_W'(cfg.still_upper) << MAG_FRAC_BITS) * HI_W'(WINDOW_LEN));
        lo_reg <= HI_W'((HI_W'(cfg.still_lower) << MAG_FRAC_BITS) * HI_W'(WINDOW_LEN));
        if (do_upd)
        begin
            ring_mem[ptr_reg] <= mag;
        end
        if (pop)
        begin
            cur_reg <= head.item;
        end
        if (load_idle)
        begin
            res_reg.recorded     <= 1'b0;
            res_reg.sample_index <= '0;
            res_reg.rel_time_ms  <= '0;
            res_reg.out_x        <= '0;
            res_reg.out_y        <= '0;
            res_reg.out_z        <= '0;
            res_reg.last         <= 1'b0;
            res_reg.end_reason   <= mcs_pkg::END_NONE;
            res_reg.started      <= is_start && !recording_reg;
        end
        else if (load_dec)
        begin
            res_reg.recorded     <= 1'b1;
            res_reg.sample_index <= count_reg - mcs_pkg::CNT_W'(1);
            res_reg.rel_time_ms  <= cur_reg.time_ms - start_time_reg;
            res_reg.out_x        <= cur_reg.x;
            res_reg.out_y        <= cur_reg.y;
            res_reg.out_z        <= cur_reg.z;
            res_reg.last         <= (reason != mcs_pkg::END_NONE);
            res_reg.end_reason   <= reason;
            res_reg.started      <= 1'b0;
        end
    end

endmodule

// ===== design/motion_capture_segmenter.sv =====
// Top level: configuration registers, front end, queue and back end.
// A start request or an ignored beat passes the front end's square and sum stages and the
// queue, and then loads the result register. An accepted sample also waits in the back end
// for the bit-serial square root, one root bit per cycle, before the window update
// and the end decision. One ignored or start beat per cycle while the output is not
// stalled; the back end takes no new beat until it is done with an accepted sample.
// Reset (rst_n low, asynchronous): idle, no recording, configuration at its defaults.
module motion_capture_segmenter
#(
    parameter int WINDOW_LEN    = 30,
    parameter int MAG_FRAC_BITS = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mcs_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [mcs_pkg::ACC_W-1:0]     accel_x,
    input  logic signed [mcs_pkg::ACC_W-1:0]     accel_y,
    input  logic signed [mcs_pkg::ACC_W-1:0]     accel_z,
    input  logic [mcs_pkg::TIME_W-1:0]           time_ms,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 recorded,
    output logic [mcs_pkg::CNT_W-1:0]            sample_index,
    output logic [mcs_pkg::TIME_W-1:0]           rel_time_ms,
    output logic signed [mcs_pkg::ACC_W-1:0]     out_x,
    output logic signed [mcs_pkg::ACC_W-1:0]     out_y,
    output logic signed [mcs_pkg::ACC_W-1:0]     out_z,
    output logic                                 last,
    output logic [mcs_pkg::REASON_W-1:0]         end_reason,
    output logic                                 started
);

    mcs_pkg::mcs_cfg_t    cfg_reg;
    mcs_pkg::mcs_item_t   in_item;
    mcs_pkg::mcs_work_t   push_data;
    mcs_pkg::mcs_work_t   head;
    mcs_pkg::mcs_result_t result;
    logic                 push;
    logic                 pop;
    logic                 fifo_full;
    logic                 fifo_empty;

    // Register file: a write lands at any edge with cfg_wr_en high; write only while idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_period_ms <= mcs_pkg::RST_PERIOD;
            cfg_reg.min_samples      <= mcs_pkg::RST_MIN;
            cfg_reg.max_samples      <= mcs_pkg::RST_MAX;
            cfg_reg.still_upper      <= mcs_pkg::RST_UPPER;
            cfg_reg.still_lower      <= mcs_pkg::RST_LOWER;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mcs_pkg::CFG_PERIOD: cfg_reg.sample_period_ms <= cfg_data;
                mcs_pkg::CFG_MIN:    cfg_reg.min_samples      <= cfg_data[mcs_pkg::CNT_W-1:0];
                mcs_pkg::CFG_MAX:    cfg_reg.max_samples      <= cfg_data[mcs_pkg::CNT_W-1:0];
                mcs_pkg::CFG_UPPER:  cfg_reg.still_upper      <= cfg_data;
                mcs_pkg::CFG_LOWER:  cfg_reg.still_lower      <= cfg_data;
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Bundle the input beat for the front end.
    always_comb
    begin
        in_item.cmd     = cmd;
        in_item.x       = accel_x;
        in_item.y       = accel_y;
        in_item.z       = accel_z;
        in_item.time_ms = time_ms;
    end

    // Front end: square the three axes, then sum them, with its own stall chain.
    mcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    // Hold up to two prepared beats while the back end works on a sample.
    mcs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // Back end: classify each beat against the recording state, take the root,
    // advance the magnitude window and decide whether the recording ends.
    mcs_back #(
        .WINDOW_LEN    (WINDOW_LEN),
        .MAG_FRAC_BITS (MAG_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (fifo_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign recorded     = result.recorded;
    assign sample_index = result.sample_index;
    assign rel_time_ms  = result.rel_time_ms;
    assign out_x        = result.out_x;
    assign out_y        = result.out_y;
    assign out_z        = result.out_z;
    assign last         = result.last;
    assign end_reason   = result.end_reason;
    assign started      = result.started;

endmodule

// ===== design/mcs_checker.sv =====
// Port-level checker for the motion capture segmenter, bound to the top level.
module mcs_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              recorded,
    input logic [mcs_pkg::CNT_W-1:0]         sample_index,
    input logic [mcs_pkg::TIME_W-1:0]        rel_time_ms,
    input logic                              last,
    input logic [mcs_pkg::REASON_W-1:0]      end_reason,
    input logic                              started
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rel_time_ms) && $stable(sample_index)
                                   && $stable(end_reason))
        else $error("stalled result beat changed");

    // An ignored beat carries nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !recorded |-> !last && (end_reason == mcs_pkg::END_NONE)
                                   && (sample_index == '0) && (rel_time_ms == '0))
        else $error("ignored beat carries data");

    // A start report never comes with a recorded sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && started |-> !recorded)
        else $error("start and sample in one beat");

    // The end flag and the end reason agree, and the reason is a legal code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && recorded |-> (last == (end_reason != mcs_pkg::END_NONE))
                                  && (end_reason == mcs_pkg::END_NONE
                                      || end_reason == mcs_pkg::END_STILL
                                      || end_reason == mcs_pkg::END_MAX))
        else $error("end flag and reason disagree");

endmodule

bind motion_capture_segmenter mcs_checker u_mcs_checker (.*);
